// ===== design/mcg_pkg.sv =====
// ----------------------------------------------------------------------------
// mcg_pkg: month calendar grid shared types
// Payload structs, queue entry, month codes and the small lookup functions.
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int Rows    = 6;
  localparam int Cols    = 7;
  localparam int DayBias = 8;

  localparam logic [3:0] MonJan = 4'd1;
  localparam logic [3:0] MonFeb = 4'd2;
  localparam logic [3:0] MonApr = 4'd4;
  localparam logic [3:0] MonJun = 4'd6;
  localparam logic [3:0] MonSep = 4'd9;
  localparam logic [3:0] MonNov = 4'd11;
  localparam logic [3:0] MonDec = 4'd12;

  localparam logic [14:0] CycleShift = 15'd400;
  localparam logic [10:0] Recip25    = 11'd1311;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
  } mcg_in_t;

  typedef struct packed {
    logic [4:0] sunday_day;
    logic [4:0] monday_day;
    logic [4:0] tuesday_day;
    logic [4:0] wednesday_day;
    logic [4:0] thursday_day;
    logic [4:0] friday_day;
    logic [4:0] saturday_day;
    logic       last_row;
  } mcg_out_t;

  typedef struct packed {
    logic [2:0] start;
    logic [4:0] len;
  } mcg_job_t;

  // floor(31 * ms / 12) for the shifted month ms
  function automatic logic [4:0] month_offset(input logic [3:0] ms);
    logic [4:0] r;
    unique case (ms)
      4'd1:    r = 5'd2;
      4'd2:    r = 5'd5;
      4'd3:    r = 5'd7;
      4'd4:    r = 5'd10;
      4'd5:    r = 5'd12;
      4'd6:    r = 5'd15;
      4'd7:    r = 5'd18;
      4'd8:    r = 5'd20;
      4'd9:    r = 5'd23;
      4'd10:   r = 5'd25;
      4'd11:   r = 5'd28;
      4'd12:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] r;
    if (mon == MonApr || mon == MonJun || mon == MonSep || mon == MonNov) begin
      r = 5'd30;
    end else if (mon == MonFeb) begin
      r = leap ? 5'd29 : 5'd28;
    end else begin
      r = 5'd31;
    end
    return r;
  endfunction

endpackage

// ===== design/mcg_front.sv =====
// ----------------------------------------------------------------------------
// mcg_front: request classification pipeline
// Clamps the month, finds the first weekday and the month length in three
// stages and hands a job to the queue.
// ----------------------------------------------------------------------------
module mcg_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mcg_pkg::mcg_in_t  in_data,
  output logic              job_push,
  output mcg_pkg::mcg_job_t job_data,
  input  logic              job_full
);
  import mcg_pkg::*;

  logic        a_valid_r, b_valid_r, c_valid_r;
  logic        a_ready, b_ready, c_ready;
  logic [3:0]  mon_c;
  logic [14:0] y_c, ys_c;
  logic [3:0]  ms_c;
  logic        shift_c;

  logic [14:0] ys_a_r;
  logic [3:0]  ms_a_r, mon_a_r;
  logic [14:0] ys_b_r;
  logic [3:0]  ms_b_r, mon_b_r;
  logic [23:0] prod_b_r;
  logic [14:0] sum_c_r;
  logic [4:0]  len_c_r;

  logic [8:0]  q100;
  logic [6:0]  q400;
  logic [15:0] sum;
  logic [14:0] r100, r400;
  logic        leap;
  logic [5:0]  fold1;
  logic [3:0]  fold2;

  assign c_ready  = !c_valid_r || !job_full;
  assign b_ready  = !b_valid_r || c_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_stall = !a_ready;

  always_comb begin
    if (in_data.month < MonJan) begin
      mon_c = MonJan;
    end else if (in_data.month > MonDec) begin
      mon_c = MonDec;
    end else begin
      mon_c = in_data.month;
    end
    shift_c = (mon_c <= MonFeb);
    y_c     = {1'b0, in_data.year} + CycleShift;
    ys_c    = y_c - {14'd0, shift_c};
    ms_c    = shift_c ? (mon_c + 4'd10) : (mon_c - 4'd2);
  end

  always_comb begin
    q100  = prod_b_r[23:15];
    q400  = q100[8:2];
    sum   = 16'd1 + {1'b0, ys_b_r} + {3'd0, ys_b_r[14:2]} - {7'd0, q100}
          + {9'd0, q400} + {11'd0, month_offset(ms_b_r)};
    r100  = ys_b_r - 15'(q100 * 7'd100);
    r400  = ys_b_r - 15'(q400 * 9'd400);
    leap  = (ys_b_r[1:0] == 2'd3 && r100 != 15'd99) || r400 == 15'd399;
    fold1 = {3'd0, sum_c_r[2:0]} + {3'd0, sum_c_r[5:3]} + {3'd0, sum_c_r[8:6]}
          + {3'd0, sum_c_r[11:9]} + {3'd0, sum_c_r[14:12]};
    fold2 = {1'b0, fold1[2:0]} + {1'b0, fold1[5:3]};
  end

  assign job_push       = c_valid_r && !job_full;
  assign job_data.start = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
  assign job_data.len   = len_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_ready) a_valid_r <= in_valid;
      if (b_ready) b_valid_r <= a_valid_r;
      if (c_ready) c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      ys_a_r  <= ys_c;
      ms_a_r  <= ms_c;
      mon_a_r <= mon_c;
    end
    if (b_ready && a_valid_r) begin
      ys_b_r   <= ys_a_r;
      ms_b_r   <= ms_a_r;
      mon_b_r  <= mon_a_r;
      prod_b_r <= ys_a_r[14:2] * Recip25;
    end
    if (c_ready && b_valid_r) begin
      sum_c_r <= sum[14:0];
      len_c_r <= month_len(mon_b_r, leap);
    end
  end

endmodule

// ===== design/mcg_fifo.sv =====
// ----------------------------------------------------------------------------
// mcg_fifo: job queue
// Short queue between the classification pipeline and the row generator.
// ----------------------------------------------------------------------------
module mcg_fifo #(
  parameter int Depth = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mcg_pkg::mcg_job_t push_data,
  output logic              full,
  input  logic              pop,
  output mcg_pkg::mcg_job_t pop_data,
  output logic              empty
);
  import mcg_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  mcg_job_t          mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   cnt_r;

  assign full     = (cnt_r == CntW'(Depth));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== design/mcg_back.sv =====
// ----------------------------------------------------------------------------
// mcg_back: week row generator
// Turns a job into six registered week rows, one a cycle unless stalled.
// ----------------------------------------------------------------------------
module mcg_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  mcg_pkg::mcg_job_t job_data,
  output logic              job_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output mcg_pkg::mcg_out_t out_data
);
  import mcg_pkg::*;

  logic       busy_r, busy_nxt;
  logic [2:0] row_r, row_nxt;
  logic [5:0] off_r, off_nxt;
  logic [4:0] len_r;
  logic       out_valid_r, out_valid_nxt;
  mcg_out_t   out_data_r;
  logic       out_ready, emit, last, load;
  logic [4:0] cells [Cols];
  logic [5:0] pos   [Cols];
  logic [5:0] limit;

  assign out_ready = !out_valid_r || !out_stall;
  assign emit      = busy_r && out_ready;
  assign last      = (row_r == 3'(Rows - 1));
  assign load      = job_valid && (!busy_r || (emit && last));
  assign job_pop   = load;
  assign limit     = {1'b0, len_r} + 6'(DayBias);

  always_comb begin
    for (int c = 0; c < Cols; c++) begin
      pos[c]   = off_r + 6'(c + 1);
      cells[c] = (pos[c] > 6'(DayBias) && pos[c] <= limit) ? 5'(pos[c] - 6'(DayBias)) : 5'd0;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    off_nxt  = off_r;
    if (load) begin
      busy_nxt = 1'b1;
      row_nxt  = '0;
      off_nxt  = 6'(DayBias) - {3'd0, job_data.start};
    end else if (emit) begin
      busy_nxt = !last;
      row_nxt  = row_r + 3'd1;
      off_nxt  = off_r + 6'(Cols);
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    if (load) len_r <= job_data.len;
    if (emit) begin
      out_data_r.sunday_day    <= cells[0];
      out_data_r.monday_day    <= cells[1];
      out_data_r.tuesday_day   <= cells[2];
      out_data_r.wednesday_day <= cells[3];
      out_data_r.thursday_day  <= cells[4];
      out_data_r.friday_day    <= cells[5];
      out_data_r.saturday_day  <= cells[6];
      out_data_r.last_row      <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/month_calendar_grid_core.sv =====
// ----------------------------------------------------------------------------
// month_calendar_grid_core: Gregorian month calendar grid
// Takes a year and a month on the in_ channel and returns six week rows,
// Sunday first, on the out_ channel.
//
// Each beat on in_ (in_valid high, in_stall low) carries a year and a month;
// months below one read as January, above twelve as December. The request
// produces exactly six beats on out_, one week row each: seven day numbers
// with 0 for an empty cell, and last_row set on the sixth row.
// While out_stall stays low the row generator emits one row per cycle, so
// the sustained request rate is set by the six row beats per request; new
// requests are taken meanwhile into the three-stage front pipeline and the
// job queue (QueueDepth entries) until those fill.
// When the receiver raises out_stall, the current row holds in the output
// register, the row generator pauses, and once queue and pipeline are full
// in_stall rises. Reset empties pipeline, queue and output; no rows are lost
// or repeated across a stall.
// ----------------------------------------------------------------------------
module month_calendar_grid_core #(
  parameter int QueueDepth = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mcg_pkg::mcg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mcg_pkg::mcg_out_t out_data
);
  import mcg_pkg::*;

  logic     job_push, job_full, job_pop, job_empty;
  mcg_job_t job_in, job_out;

  mcg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .job_push (job_push),
    .job_data (job_in),
    .job_full (job_full)
  );

  mcg_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty)
  );

  mcg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!job_empty),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/mcg_grid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_grid_checker: week row scoreboard for the month calendar grid
// Watches the request and row channels of month_calendar_grid_core. Every
// accepted request is expanded into its six week rows. Every accepted row
// is compared, cell by cell, with the oldest row still due.
// ----------------------------------------------------------------------------
module mcg_grid_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  mcg_pkg::mcg_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  mcg_pkg::mcg_out_t out_data,
  output int                fail_count,
  output int                rows_pending
);
  import mcg_pkg::*;

  localparam string DayName [Cols] = '{"sun", "mon", "tue", "wed", "thu", "fri", "sat"};

  mcg_out_t week_rows_due [$];
  int       mismatches;

  initial begin
    mismatches = 0;
  end

  function automatic logic [4:0] cell_of(mcg_out_t row, int col);
    logic [4:0] d;
    case (col)
      0:       d = row.sunday_day;
      1:       d = row.monday_day;
      2:       d = row.tuesday_day;
      3:       d = row.wednesday_day;
      4:       d = row.thursday_day;
      5:       d = row.friday_day;
      default: d = row.saturday_day;
    endcase
    return d;
  endfunction

  function automatic bit is_leap(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // Expand one request into its six week rows, Sunday first.
  function automatic void queue_month_rows(mcg_in_t req);
    int unsigned mon, y, len, shift, ys, ms, start, day;
    logic [4:0]  cells [Cols];
    mcg_out_t    row;
    mon = req.month;
    if (mon < MonJan) mon = MonJan;
    if (mon > MonDec) mon = MonDec;
    y = int'(req.year) + 400;
    if (mon == MonApr || mon == MonJun || mon == MonSep || mon == MonNov) begin
      len = 30;
    end else if (mon == MonFeb) begin
      len = is_leap(y) ? 29 : 28;
    end else begin
      len = 31;
    end
    shift = (14 - mon) / 12;
    ys    = y - shift;
    ms    = mon + 12 * shift - 2;
    start = (1 + ys + ys / 4 - ys / 100 + ys / 400 + (31 * ms) / 12) % 7;
    day   = 0;
    for (int r = 0; r < Rows; r++) begin
      for (int c = 0; c < Cols; c++) begin
        cells[c] = 5'd0;
        if (r == 0) begin
          if (c >= start) begin
            day++;
            cells[c] = day[4:0];
          end
        end else if (day < len) begin
          day++;
          cells[c] = day[4:0];
        end
      end
      row.sunday_day    = cells[0];
      row.monday_day    = cells[1];
      row.tuesday_day   = cells[2];
      row.wednesday_day = cells[3];
      row.thursday_day  = cells[4];
      row.friday_day    = cells[5];
      row.saturday_day  = cells[6];
      row.last_row      = (r == Rows - 1);
      week_rows_due.push_back(row);
    end
  endfunction

  always @(posedge clk) begin
    mcg_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (week_rows_due.size() == 0) begin
          $display("%0t: unexpected row %h", $time, out_data);
          mismatches++;
        end else begin
          want = week_rows_due.pop_front();
          for (int c = 0; c < Cols; c++) begin
            if (cell_of(out_data, c) !== cell_of(want, c)) begin
              $display("%0t: %s expected %0d got %0d", $time, DayName[c],
                       cell_of(want, c), cell_of(out_data, c));
              mismatches++;
            end
          end
          if (out_data.last_row !== want.last_row) begin
            $display("%0t: last_row expected %0b got %0b", $time,
                     want.last_row, out_data.last_row);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) queue_month_rows(in_data);
    end
    fail_count   <= mismatches;
    rows_pending <= week_rows_due.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: month calendar grid testbench
// Sends directed year/month requests (range ends, clamped months, leap and
// century years) and then random ones in bursts, while the row receiver
// stalls on its own pattern with one long hold-off. The checker predicts
// every week row and reports mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import mcg_pkg::*;

  typedef enum int {StallNone, StallLight, StallHeavy} stall_mode_e;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  mcg_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  mcg_out_t out_data;
  int       fail_count;
  int       rows_pending;
  int       requests_sent = 0;
  int       burst_left    = 4;

  month_calendar_grid_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  mcg_grid_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .rows_pending (rows_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_request(input logic [13:0] yr, input logic [3:0] mo);
    int gap;
    in_data  <= '{year: yr, month: mo};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
    end
  endtask

  // receiver: random stall patterns, one long hold-off once traffic is flowing
  initial begin
    stall_mode_e mode;
    int          span;
    bit          held;
    held = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held && requests_sent >= 40) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (90) @(posedge clk);
      end
      mode = stall_mode_e'($urandom_range(0, 2));
      span = $urandom_range(10, 60);
      repeat (span) begin
        case (mode)
          StallNone:  out_stall <= 1'b0;
          StallLight: out_stall <= ($urandom_range(0, 3) == 0);
          default:    out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [13:0] yr;
    logic [3:0]  mo;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(14'd2024, MonFeb);
    send_request(14'd2023, MonFeb);
    send_request(14'd2000, MonFeb);
    send_request(14'd1900, MonFeb);
    send_request(14'd0,    MonFeb);
    send_request(14'd0,    4'd0);
    send_request(14'd1,    MonJan);
    send_request(14'd9999, MonDec);
    send_request(14'd16383, 4'd15);
    send_request(14'd10000, 4'd13);
    send_request(14'd2100, MonFeb);
    send_request(14'd2400, MonFeb);
    send_request(14'd5461, 4'd14);
    send_request(14'd10922, 4'd5);
    for (int m = 1; m <= 12; m++) send_request(14'd2015, m[3:0]);

    repeat (154) begin
      yr = ($urandom_range(0, 4) == 0) ? 14'($urandom) : 14'($urandom_range(1, 9999));
      mo = ($urandom_range(0, 6) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
      send_request(yr, mo);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
